// ===== sv/crc8lf_pkg.sv =====
// ----------------------------------------------------------------------------
// crc8lf_pkg
// Types and helpers for the length-prefixed frame parser: the frame phase,
// the result record and the byte-wide CRC-8 update (polynomial 0x07).
// ----------------------------------------------------------------------------
package crc8lf_pkg;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;

  typedef enum logic [2:0] {
    PH_TARGET  = 3'd0,
    PH_OPCODE  = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC     = 3'd4
  } phase_t;

  typedef enum logic {
    KIND_PAYLOAD   = 1'b0,
    KIND_FRAME_END = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic [7:0] target_id;
    logic [7:0] op_code;
    logic [7:0] payload_len;
    logic       crc_ok;
    logic [7:0] computed_crc;
  } res_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// ===== sv/crc8_length_frame_parser.sv =====
// ----------------------------------------------------------------------------
// crc8_length_frame_parser
// Parses target, opcode, length, payload and CRC-8 bytes of a received frame,
// passing payload bytes out and closing each frame with a CRC check result.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  rx_byte, frame_start
//  out      out_valid/out_stall  kind, payload_byte, target_id, op_code,
//                                payload_len, crc_ok, computed_crc
//
// One byte per cycle while in_stall is low; results are registered. The CRC
// update is byte-wide XOR logic between the frame state registers and the
// output register; a two-entry output stage (register plus skid) lets requests
// flow while a result waits. in_stall rises only when both entries are full.
// Reset clears the phase, held header and valid bits.
// ----------------------------------------------------------------------------
module crc8_length_frame_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       kind,
  output logic [7:0] payload_byte,
  output logic [7:0] target_id,
  output logic [7:0] op_code,
  output logic [7:0] payload_len,
  output logic       crc_ok,
  output logic [7:0] computed_crc
);
  import crc8lf_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] held_target, held_target_next;
  logic [7:0] held_opcode, held_opcode_next;
  logic [7:0] held_length, held_length_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_crc, running_crc_next;

  res_t       res;
  logic       res_fire;
  res_t       out_res;
  res_t       skid_res;
  logic       skid_valid;
  logic       accept;
  logic       take;
  logic [7:0] crc_upd;
  logic [7:0] left_dec;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign take     = out_valid && !out_stall;
  assign left_dec = bytes_left - 8'd1;

  always_comb begin
    phase_t ph;
    ph               = frame_start ? PH_TARGET : phase;
    phase_next       = phase;
    held_target_next = held_target;
    held_opcode_next = held_opcode;
    held_length_next = held_length;
    bytes_left_next  = bytes_left;
    crc_upd          = crc8_byte(running_crc, rx_byte);
    running_crc_next = running_crc;
    res_fire         = 1'b0;
    res.kind         = KIND_PAYLOAD;
    res.payload_byte = 8'h00;
    res.target_id    = held_target;
    res.op_code      = held_opcode;
    res.payload_len  = held_length;
    res.crc_ok       = 1'b0;
    res.computed_crc = running_crc;
    unique case (ph)
      PH_OPCODE: begin
        held_opcode_next = rx_byte;
        running_crc_next = crc_upd;
        phase_next       = PH_LENGTH;
      end
      PH_LENGTH: begin
        held_length_next = rx_byte;
        bytes_left_next  = rx_byte;
        running_crc_next = crc_upd;
        phase_next       = (rx_byte == 8'h00) ? PH_CRC : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        running_crc_next = crc_upd;
        bytes_left_next  = left_dec;
        if (left_dec == 8'h00) begin
          phase_next = PH_CRC;
        end
        res_fire         = 1'b1;
        res.payload_byte = rx_byte;
        res.computed_crc = crc_upd;
      end
      PH_CRC: begin
        res_fire   = 1'b1;
        res.kind   = KIND_FRAME_END;
        res.crc_ok = (rx_byte == running_crc);
        phase_next = PH_TARGET;
      end
      default: begin
        held_target_next = rx_byte;
        held_opcode_next = 8'h00;
        held_length_next = 8'h00;
        bytes_left_next  = 8'h00;
        running_crc_next = crc8_byte(CRC_INIT, rx_byte);
        phase_next       = PH_OPCODE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TARGET;
      held_target <= 8'h00;
      held_opcode <= 8'h00;
      held_length <= 8'h00;
      bytes_left  <= 8'h00;
      running_crc <= CRC_INIT;
    end else if (accept) begin
      phase       <= phase_next;
      held_target <= held_target_next;
      held_opcode <= held_opcode_next;
      held_length <= held_length_next;
      bytes_left  <= bytes_left_next;
      running_crc <= running_crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take || !out_valid) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (accept && res_fire) begin
        out_res   <= res;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept && res_fire) begin
      skid_res   <= res;
      skid_valid <= 1'b1;
    end
  end

  assign kind         = out_res.kind;
  assign payload_byte = out_res.payload_byte;
  assign target_id    = out_res.target_id;
  assign op_code      = out_res.op_code;
  assign payload_len  = out_res.payload_len;
  assign crc_ok       = out_res.crc_ok;
  assign computed_crc = out_res.computed_crc;

endmodule
